[sv/pst_pkg.sv]
// ----------------------------------------------------------------------------
// pst_pkg: shared definitions for the transmit PDO sync scheduler
// Holds the PDO count, the index width, the request kind codes, the transmission
// type limits and the sequencer states used by the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

	// Number of transmit PDOs kept by the scheduler (1 to 8).
	localparam int NUM_PDOS = 8;

	// Width of a PDO index as carried on the request port.
	localparam int PIDX_W = 3;

	// Request kind codes.
	localparam logic [2:0] KIND_SYNC    = 3'd0;
	localparam logic [2:0] KIND_EVENT   = 3'd1;
	localparam logic [2:0] KIND_TWRITE  = 3'd2;
	localparam logic [2:0] KIND_TREAD   = 3'd3;
	localparam logic [2:0] KIND_SERVICE = 3'd4;

	// Transmission type limits.
	localparam logic [7:0] TYPE_ACYCLIC    = 8'd0;
	localparam logic [7:0] CYCLIC_MAX      = 8'd240;
	localparam logic [7:0] TYPE_RTR_SYNC   = 8'd254;
	localparam logic [7:0] TYPE_RTR_ASYNC  = 8'd255;

	// Sequencer states.
	typedef enum logic {
		ST_IDLE,
		ST_SYNC
	} state_t;

endpackage

`default_nettype wire

[sv/pdo_sync_transmit_scheduler.sv]
// ----------------------------------------------------------------------------
// pdo_sync_transmit_scheduler: transmit PDO sync transmission scheduler
// Keeps a transmission type, a sync counter, a waiting flag and a queued flag
// for each transmit PDO, and walks all PDOs with one shared decrementer on a
// sync request.
// ----------------------------------------------------------------------------
//
//  Channel    Handshake                Payload
//  ---------  -----------------------  ------------------------------------
//  request    req_valid / req_ready    kind, pdo_index, type_value,
//                                      ready_mask
//  response   rsp_valid / rsp_ready    sent_mask, type_out, range_error
//
// Every request produces exactly one response, which is loaded into the
// response register in the cycle the request is accepted. Event, type write,
// type read and transmit service requests finish in that same cycle. A sync
// request then occupies the block while the sequencer walks the PDO table:
// it visits one PDO entry per cycle through the single shared decrement and
// compare unit, and req_ready stays low until the walk is done.
// A new request is taken while the response register is empty or is being
// drained in the same cycle, so a stalled response holds off only the next
// request. Reset clears all PDO state, the sequencer and the response valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pdo_sync_transmit_scheduler
	import pst_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic [2:0]        kind,
	input  wire logic [PIDX_W-1:0] pdo_index,
	input  wire logic [7:0]        type_value,
	input  wire logic [7:0]        ready_mask,

	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output logic [7:0]             sent_mask,
	output logic [7:0]             type_out,
	output logic                   range_error
);

	// Mask of the PDO positions that exist.
	localparam logic [7:0] PDO_MASK = 8'((9'd1 << NUM_PDOS) - 9'd1);
	localparam logic [PIDX_W-1:0] LAST_PDO = PIDX_W'(NUM_PDOS - 1);

	// Sequencer.
	state_t             state_q;
	state_t             state_d;
	logic [PIDX_W-1:0]  walk_q;

	// Per-PDO state.
	logic [7:0]         tx_type_q    [NUM_PDOS];
	logic [7:0]         sync_count_q [NUM_PDOS];
	logic [NUM_PDOS-1:0] waiting_q;
	logic [NUM_PDOS-1:0] queued_q;

	// Response register.
	logic               rsp_valid_q;
	logic [7:0]         sent_mask_q;
	logic [7:0]         type_out_q;
	logic               range_error_q;

	// Request decode.
	logic               accept;
	logic               idx_ok;
	logic               val_cyclic;
	logic               val_rtr;
	logic               walking;
	logic               walk_last;

	// Shared entry read port and decrementer.
	logic [PIDX_W-1:0]  rd_addr;
	logic [7:0]         rd_type;
	logic [7:0]         rd_cnt;
	logic [7:0]         cnt_dec;
	logic               rd_acyclic;
	logic               rd_cyclic;

	// Service result.
	logic [NUM_PDOS-1:0] serve_hits;

	assign accept     = req_valid && req_ready;
	assign idx_ok     = ({1'b0, pdo_index} < (PIDX_W+1)'(NUM_PDOS));
	assign val_cyclic = (type_value <= CYCLIC_MAX);
	assign val_rtr    = (type_value == TYPE_RTR_SYNC) || (type_value == TYPE_RTR_ASYNC);
	assign walk_last  = (walk_q == LAST_PDO);

	// One read address serves both the sync walk and a type read.
	assign rd_addr    = walking ? walk_q : pdo_index;
	assign rd_type    = tx_type_q[rd_addr];
	assign rd_cnt     = sync_count_q[rd_addr];
	assign cnt_dec    = rd_cnt - 8'd1;
	assign rd_acyclic = (rd_type == TYPE_ACYCLIC);
	assign rd_cyclic  = !rd_acyclic && (rd_type <= CYCLIC_MAX);

	assign serve_hits = ready_mask[NUM_PDOS-1:0] & queued_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (kind == KIND_SYNC)) begin
					state_d = ST_SYNC;
				end
			end
			ST_SYNC: begin
				if (walk_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		walking   = 1'b0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = !rsp_valid_q || rsp_ready;
			end
			ST_SYNC: begin
				walking = 1'b1;
			end
			default: begin
				walking   = 1'b0;
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			walk_q  <= '0;
		end else begin
			state_q <= state_d;
			if (walking) begin
				walk_q <= walk_last ? '0 : walk_q + PIDX_W'(1);
			end
		end
	end

	// PDO state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PDOS; i++) begin
				tx_type_q[i]    <= '0;
				sync_count_q[i] <= '0;
			end
			waiting_q <= '0;
			queued_q  <= '0;
		end else if (walking) begin
			// One PDO entry per cycle through the shared decrementer.
			if (rd_acyclic) begin
				if (waiting_q[walk_q]) begin
					waiting_q[walk_q] <= 1'b0;
					queued_q[walk_q]  <= 1'b1;
				end
			end else if (rd_cyclic) begin
				if (cnt_dec == 8'd0) begin
					sync_count_q[walk_q] <= rd_type;
					queued_q[walk_q]     <= 1'b1;
				end else begin
					sync_count_q[walk_q] <= cnt_dec;
				end
			end
		end else if (accept) begin
			unique case (kind)
				KIND_EVENT: begin
					if (idx_ok) begin
						waiting_q[pdo_index] <= 1'b1;
					end
				end
				KIND_TWRITE: begin
					if (idx_ok) begin
						if (val_cyclic) begin
							tx_type_q[pdo_index]    <= type_value;
							sync_count_q[pdo_index] <= type_value;
						end else if (val_rtr) begin
							tx_type_q[pdo_index] <= type_value;
						end
					end
				end
				KIND_SERVICE: begin
					queued_q <= queued_q & ~serve_hits;
				end
				default: begin
				end
			endcase
		end
	end

	// Response register: loaded on every accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sent_mask_q   <= '0;
			type_out_q    <= '0;
			range_error_q <= 1'b0;
			unique case (kind)
				KIND_TWRITE: begin
					range_error_q <= idx_ok && !val_cyclic && !val_rtr;
				end
				KIND_TREAD: begin
					if (idx_ok) begin
						type_out_q <= rd_type;
					end
				end
				KIND_SERVICE: begin
					sent_mask_q <= 8'(serve_hits) & PDO_MASK;
				end
				default: begin
				end
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign sent_mask   = sent_mask_q;
	assign type_out    = type_out_q;
	assign range_error = range_error_q;

endmodule

`default_nettype wire
